// ===== rtl/core/sobel_edge_rgb_stream_macros.svh =====
// Assertion macros used by the edge detector controller.
// No dependencies.
`ifndef SOBEL_EDGE_RGB_STREAM_MACROS_SVH
`define SOBEL_EDGE_RGB_STREAM_MACROS_SVH
`define SER_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("lbl");
`define SER_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("lbl");
`endif

// ===== rtl/core/ser_pkg.sv =====
// Package for the RGB Sobel edge block: sizes, constants and shared types.
// No dependencies.
`default_nettype none
package ser_pkg;
  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 1024;
  localparam int CfgW   = 11;
  localparam int PixW   = 24;
  localparam int EdgeMax = 255;
  localparam logic [1:0] AddrWidth  = 2'd0;
  localparam logic [1:0] AddrHeight = 2'd1;

  typedef struct packed {
    logic load;
    logic shift;
    logic root_start;
    logic out_load;
  } ser_cmd_t;

  typedef struct packed {
    logic root_done;
    logic emit;
  } ser_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/sobel_edge_rgb_stream.sv =====
// Per-channel 3x3 Sobel edge magnitude over an RGB raster stream. An item is
// taken only when idle and passes the transfer, a store read, a window shift,
// a square stage, a twelve-step bit-serial square root and the output load
// before the next is taken; a result still held by the receiver holds the
// next item at its output load; ignored items give no result. Results trail
// their pixel by width+1 items; drain ticks (command=1) flush a frame's tail.
// Depends on ser_pkg, ser_ctrl, ser_datapath.
`default_nettype none
module sobel_edge_rgb_stream #(
  parameter int MaxWidth  = ser_pkg::MaxWidthDef,
  parameter int MaxHeight = ser_pkg::MaxHeightDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [7:0]  red_in,
  input  wire logic [7:0]  green_in,
  input  wire logic [7:0]  blue_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       red_edge,
  output logic [7:0]       green_edge,
  output logic [7:0]       blue_edge,
  output logic             frame_end
);
  logic [ser_pkg::CfgW-1:0] image_width, image_height;
  ser_pkg::ser_cmd_t cmd;
  ser_pkg::ser_sts_t sts;
  logic drop;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= ser_pkg::CfgW'(640); image_height <= ser_pkg::CfgW'(480);
    end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'd0) begin
      if (paddr[2] == ser_pkg::AddrWidth[0]) image_width <= pwdata[ser_pkg::CfgW-1:0];
      else if (paddr[2] == ser_pkg::AddrHeight[0]) image_height <= pwdata[ser_pkg::CfgW-1:0];
    end
  end
  always_comb begin
    case (paddr[2])
      ser_pkg::AddrWidth[0]:  prdata = 32'(image_width);
      ser_pkg::AddrHeight[0]: prdata = 32'(image_height);
      default: prdata = '0;
    endcase
  end
  ser_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .drop(drop),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts));
  ser_datapath #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .busy_drop(drop),
    .command(command), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .image_width(image_width), .image_height(image_height),
    .red_edge(red_edge), .green_edge(green_edge), .blue_edge(blue_edge),
    .frame_end(frame_end));
endmodule
`default_nettype wire

// ===== rtl/core/ser_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module ser_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/ser_datapath.sv =====
// Datapath: line stores, window, frame counters, gradients, iterative roots.
// Depends on ser_pkg and ser_ram.
`default_nettype none
module ser_datapath #(
  parameter int MaxWidth  = ser_pkg::MaxWidthDef,
  parameter int MaxHeight = ser_pkg::MaxHeightDef
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire ser_pkg::ser_cmd_t       cmd,
  output ser_pkg::ser_sts_t            sts,
  output logic                         busy_drop,
  input  wire logic                    command,
  input  wire logic [7:0]              red_in,
  input  wire logic [7:0]              green_in,
  input  wire logic [7:0]              blue_in,
  input  wire logic [ser_pkg::CfgW-1:0] image_width,
  input  wire logic [ser_pkg::CfgW-1:0] image_height,
  output logic [7:0]                   red_edge,
  output logic [7:0]                   green_edge,
  output logic [7:0]                   blue_edge,
  output logic                         frame_end
);
  localparam int CW = $clog2(MaxWidth);
  localparam int DW = $clog2(MaxWidth + 1);
  localparam int HW = $clog2(MaxHeight + 1);
  localparam int TW = DW + HW;
  localparam int PW = ser_pkg::PixW;

  logic [DW-1:0] frame_w;
  logic [HW-1:0] frame_h;
  logic [DW-1:0] col;
  logic [HW-1:0] row;
  logic [TW-1:0] emitted;
  logic [DW-1:0] q_col;
  logic [HW-1:0] q_row;
  logic [TW-1:0] pos;
  logic [PW-1:0] win [3][3];
  logic [PW-1:0] up_rd, mid_rd;
  logic [PW-1:0] pix_hold;
  logic [CW-1:0] col_hold;
  logic          filled;
  logic [DW-1:0] w_cl;
  logic [HW-1:0] h_cl;
  logic          start_frame;
  logic [TW-1:0] total;
  logic          valid_item;
  logic [CW-1:0] col_idx;
  logic          emit_c;
  logic          last_c;
  logic          pend_emit, pend_last;

  always_comb begin
    if (image_width == '0) w_cl = DW'(1);
    else if (32'(image_width) > 32'(MaxWidth)) w_cl = DW'(MaxWidth);
    else w_cl = DW'(image_width);
    if (image_height == '0) h_cl = HW'(1);
    else if (32'(image_height) > 32'(MaxHeight)) h_cl = HW'(MaxHeight);
    else h_cl = HW'(image_height);
  end

  logic [DW-1:0] fw_eff;
  logic [HW-1:0] fh_eff;
  assign start_frame = !command && row == '0 && col == '0;
  assign fw_eff = start_frame ? w_cl : frame_w;
  assign fh_eff = start_frame ? h_cl : frame_h;
  assign total  = TW'(frame_w) * TW'(frame_h);
  assign valid_item = (row < fh_eff) ? !command : (command && emitted < TW'(fw_eff) * TW'(fh_eff));
  assign busy_drop = !valid_item;
  assign col_idx = (col >= DW'(MaxWidth)) ? CW'(MaxWidth - 1) : col[CW-1:0];

  ser_ram #(.Width(PW), .Depth(MaxWidth)) u_up (
    .clk(clk), .we(cmd.shift), .waddr(col_hold), .wdata(mid_rd),
    .raddr(col_hold), .rdata(up_rd));
  ser_ram #(.Width(PW), .Depth(MaxWidth)) u_mid (
    .clk(clk), .we(cmd.shift), .waddr(col_hold), .wdata(pix_hold),
    .raddr(col_hold), .rdata(mid_rd));

  // load: set store address, advance counters; shift: update window and stores; output load: count results
  logic [TW-1:0] pos_next;
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; row <= '0; emitted <= '0; filled <= 1'b0;
      frame_w <= DW'(640); frame_h <= HW'(480);
      q_col <= '0; q_row <= '0; pend_emit <= 1'b0; pend_last <= 1'b0;
      for (int r = 0; r < 3; r++) for (int c = 0; c < 3; c++) win[r][c] <= '0;
    end else begin
      if (cmd.load) begin
        if (start_frame) begin
          frame_w <= w_cl; frame_h <= h_cl; filled <= 1'b0;
          q_col <= '0; q_row <= '0; pos <= '0;
        end
        pix_hold <= (row < fh_eff) ? {blue_in, green_in, red_in} : '0;
        col_hold <= col_idx;
        if (col + 1'b1 >= fw_eff) begin
          col <= '0; row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      if (cmd.shift) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= up_rd;
        win[1][2] <= mid_rd;
        win[2][2] <= pix_hold;
        pos <= pos_next;
        pend_emit <= emit_c;
        pend_last <= last_c;
        if (emit_c) begin
          if (filled) begin
            if (q_col + 1'b1 >= frame_w) begin
              q_col <= '0; q_row <= q_row + 1'b1;
            end else q_col <= q_col + 1'b1;
          end
          filled <= 1'b1;
        end
      end
      if (cmd.out_load && pend_emit) begin
        if (emitted + 1'b1 >= total) begin
          emitted <= '0; row <= '0; col <= '0;
        end else emitted <= emitted + 1'b1;
      end
    end
  end
  assign pos_next = pos + 1'b1;
  assign emit_c = pos >= TW'(frame_w) + TW'(1);
  logic [TW-1:0] q_lin;
  assign q_lin = pos - TW'(frame_w) - TW'(1);
  assign last_c = emit_c && (q_lin + 1'b1 == total);

  // window position of the pixel now centred (advance once more if filled)
  logic [DW-1:0] cc;
  logic [HW-1:0] cr;
  always_comb begin
    cc = q_col; cr = q_row;
    if (filled) begin
      if (q_col + 1'b1 >= frame_w) begin cc = '0; cr = q_row + 1'b1; end
      else cc = q_col + 1'b1;
    end
  end
  // latched centre and masks for the computation
  logic [DW-1:0] ccl;
  logic [HW-1:0] crl;
  logic signed [11:0] gx [3], gy [3];
  logic [2:0] rok, cok;
  always_comb begin
    rok[0] = crl != '0;          rok[1] = 1'b1; rok[2] = HW'(crl + 1'b1) < frame_h;
    cok[0] = ccl != '0;          cok[1] = 1'b1; cok[2] = DW'(ccl + 1'b1) < frame_w;
  end

  // take the window as it stands after this shift
  logic [PW-1:0] wl [3][3];
  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      ccl <= cc; crl <= cr;
      for (int r = 0; r < 3; r++) begin
        wl[r][0] <= win[r][1];
        wl[r][1] <= win[r][2];
      end
      wl[0][2] <= up_rd;
      wl[1][2] <= mid_rd;
      wl[2][2] <= pix_hold;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [11:0] v [3][3];
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          v[r][c] = (rok[r] && cok[c]) ? $signed({4'd0, wl[r][c][8*k +: 8]}) : 12'sd0;
      gx[k] = (v[0][2] - v[0][0]) + 12'sd2 * (v[1][2] - v[1][0]) + (v[2][2] - v[2][0]);
      gy[k] = (v[2][0] - v[0][0]) + 12'sd2 * (v[2][1] - v[0][1]) + (v[2][2] - v[0][2]);
    end
  end

  // registered squares then bit-serial root, one bit per cycle
  logic [22:0] s [3];
  logic [11:0] n [3];
  logic [3:0]  bitn;
  logic        sq_ph, run;
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0; sq_ph <= 1'b0; bitn <= '0;
    end else if (cmd.root_start) begin
      sq_ph <= 1'b1; run <= 1'b0;
    end else if (sq_ph) begin
      for (int k = 0; k < 3; k++) begin
        s[k] <= 23'(gx[k] * gx[k]) + 23'(gy[k] * gy[k]);
        n[k] <= '0;
      end
      sq_ph <= 1'b0; run <= 1'b1; bitn <= 4'd11;
    end else if (run) begin
      for (int k = 0; k < 3; k++) begin
        logic [11:0] t;
        t = n[k] | (12'd1 << bitn);
        if (24'(t) * 24'(t) <= 24'(s[k])) n[k] <= t;
      end
      if (bitn == '0) run <= 1'b0;
      else bitn <= bitn - 1'b1;
    end
  end
  assign sts.root_done = run && bitn == '0;
  assign sts.emit = pend_emit;

  function automatic logic [7:0] fin(input logic [11:0] nn, input logic [22:0] ss);
    logic [12:0] r;
    r = {1'b0, nn};
    if (24'(ss) > 24'(nn) * 24'(nn) + 24'(nn)) r = r + 1'b1;
    return (r > 13'(ser_pkg::EdgeMax)) ? 8'(ser_pkg::EdgeMax) : r[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      red_edge <= fin(n[0], s[0]);
      green_edge <= fin(n[1], s[1]);
      blue_edge <= fin(n[2], s[2]);
      frame_end <= pend_last;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/ser_ctrl.sv =====
// Controller: sequences load, window shift, root iterations and output.
// Depends on ser_pkg and the assertion macro header.
`default_nettype none
`include "sobel_edge_rgb_stream_macros.svh"
module ser_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              drop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ser_pkg::ser_cmd_t      cmd,
  input  wire ser_pkg::ser_sts_t sts
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_SHIFT, S_ROOT, S_OUT} state_t;
  state_t state;
  assign in_stall = state != S_IDLE;
  always_comb begin
    cmd = '0;
    cmd.load       = state == S_IDLE && in_valid && !in_stall && !drop;
    cmd.shift      = state == S_SHIFT;
    cmd.root_start = state == S_SHIFT;
    cmd.out_load   = state == S_OUT && !(out_valid && out_stall);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) out_valid <= sts.emit;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE:  if (cmd.load) state <= S_READ;
        S_READ:  state <= S_SHIFT;
        S_SHIFT: state <= S_ROOT;
        S_ROOT:  if (sts.root_done) state <= S_OUT;
        S_OUT:   if (cmd.out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
  `SER_ASSERT_IMP(a_no_load_busy, clk, rst, state != S_IDLE, !cmd.load)
  `SER_ASSERT_NXT(a_read_shift, clk, rst, state == S_READ, state == S_SHIFT)
  `SER_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
endmodule
`default_nettype wire

// ===== bench/sobel_edge_rgb_stream_chk.sv =====
// Checker for sobel_edge_rgb_stream: follows register writes and transfers on
// both channels, predicts each edge result and compares it with the block.
// Depends on ser_pkg.
module sobel_edge_rgb_stream_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        command,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  red_edge,
  input  logic [7:0]  green_edge,
  input  logic [7:0]  blue_edge,
  input  logic        frame_end,
  output int          mismatches,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxDim = ser_pkg::MaxWidthDef;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fe;
  } edge_res_t;

  const int kx[3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
  const int ky[3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

  logic [ser_pkg::CfgW-1:0] width_reg, height_reg;
  logic [ser_pkg::PixW-1:0] upper_line[MaxDim];
  logic [ser_pkg::PixW-1:0] middle_line[MaxDim];
  logic [ser_pkg::PixW-1:0] win[3][3];
  int unsigned col_pos, row_pos, done_cnt, fw, fh;
  edge_res_t edge_q[$];
  int n_bad, n_res;

  assign mismatches   = n_bad;
  assign results_seen = n_res;

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v == 0) return 1;
    return (v > MaxDim) ? MaxDim : v;
  endfunction

  function automatic logic [7:0] round_root(int unsigned s);
    int unsigned n, t;
    n = 0;
    for (int b = 11; b >= 0; b--) begin
      t = n | (1 << b);
      if (t * t <= s) n = t;
    end
    if (s > n * n + n) n++;
    return (n > ser_pkg::EdgeMax) ? 8'(ser_pkg::EdgeMax) : n[7:0];
  endfunction

  function automatic logic [7:0] magnitude(int sh, int unsigned qr, int unsigned qc);
    int gx, gy, v, r, c;
    gx = 0;
    gy = 0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        r = int'(qr) + dr - 1;
        c = int'(qc) + dc - 1;
        if (r >= 0 && r < int'(fh) && c >= 0 && c < int'(fw)) begin
          v = int'((win[dr][dc] >> sh) & 24'hFF);
          gx += v * kx[dr][dc];
          gy += v * ky[dr][dc];
        end
      end
    end
    return round_root(int'(gx * gx + gy * gy));
  endfunction

  task automatic predict_edge(logic drain, logic [23:0] px_in);
    int unsigned total, pos, col, q;
    logic [23:0] px;
    edge_res_t e;
    if (!drain && row_pos == 0 && col_pos == 0) begin
      fw = clamp_dim(width_reg);
      fh = clamp_dim(height_reg);
    end
    total = fw * fh;
    if (row_pos < fh) begin
      if (drain) return;
      px = px_in;
    end else begin
      if (!drain || done_cnt >= total) return;
      px = '0;
    end
    col = (col_pos >= MaxDim) ? MaxDim - 1 : col_pos;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = upper_line[col];
    win[1][2] = middle_line[col];
    win[2][2] = px;
    upper_line[col] = middle_line[col];
    middle_line[col] = px;
    pos = row_pos * fw + col_pos;
    col_pos++;
    if (col_pos >= fw) begin
      col_pos = 0;
      row_pos++;
    end
    if (pos < fw + 1) return;
    q = pos - fw - 1;
    e.r = magnitude(0, q / fw, q % fw);
    e.g = magnitude(8, q / fw, q % fw);
    e.b = magnitude(16, q / fw, q % fw);
    e.fe = (q + 1 == total);
    edge_q.push_back(e);
    done_cnt++;
    if (done_cnt >= total) begin
      done_cnt = 0;
      row_pos = 0;
      col_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    edge_res_t got, want;
    if (rst) begin
      width_reg = 11'd640;
      height_reg = 11'd480;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_pos = 0;
      row_pos = 0;
      done_cnt = 0;
      fw = 640;
      fh = 480;
      edge_q.delete();
      n_bad = 0;
      n_res = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if ((paddr >> 2) == ser_pkg::AddrWidth) width_reg = pwdata[10:0];
        else if ((paddr >> 2) == ser_pkg::AddrHeight) height_reg = pwdata[10:0];
      end
      if (out_valid && !out_stall) begin
        got = '{red_edge, green_edge, blue_edge, frame_end};
        n_res++;
        if (edge_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result r=%0d g=%0d b=%0d end=%0b",
                                    got.r, got.g, got.b, got.fe);
        end else begin
          want = edge_q.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("result %0d: expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                       n_res, want.r, want.g, want.b, want.fe,
                       got.r, got.g, got.b, got.fe);
          end
        end
      end
      if (in_valid && !in_stall) predict_edge(command, {blue_in, green_in, red_in});
    end
    pending = edge_q.size();
  end
endmodule

// ===== bench/sobel_edge_rgb_stream_tb.sv =====
// Top of the edge detector bench: clock, reset, register writes and frame
// stimulus with random idling; verdict from checker mismatches and pending.
// Depends on sobel_edge_rgb_stream, sobel_edge_rgb_stream_chk, ser_pkg.
module sobel_edge_rgb_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1_000_000;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall, command;
  logic [7:0] red_in, green_in, blue_in;
  logic out_valid, out_stall;
  logic [7:0] red_edge, green_edge, blue_edge;
  logic frame_end;
  int mismatches, pending, results_seen;
  int send_idle, recv_idle, hold_cycles, cycle_cnt, items_sent, frames_run;

  sobel_edge_rgb_stream DUT (.*);

  sobel_edge_rgb_stream_chk chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle);
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx[0], 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic push_item(logic cmd, logic [23:0] px);
    if ($urandom_range(99, 0) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    {blue_in, green_in, red_in} <= px;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // pattern 0: random, 1: alternating extremes
  task automatic run_frame(int wr, int hr, int pattern, int noise_pct);
    int w, h, drains;
    logic [23:0] px;
    settle();
    reg_write(ser_pkg::AddrWidth, wr);
    reg_write(ser_pkg::AddrHeight, hr);
    w = (wr == 0) ? 1 : (wr > 1024 ? 1024 : wr);
    h = (hr == 0) ? 1 : (hr > 1024 ? 1024 : hr);
    drains = w + 1;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(99, 0) < noise_pct) push_item(1'b1, 24'($urandom));
      px = pattern ? (((i + i / w) % 2) ? 24'hFFFFFF : 24'h000000) : 24'($urandom);
      push_item(1'b0, px);
      items_sent++;
    end
    for (int i = 0; i < drains; i++) begin
      if (i > 0 && $urandom_range(99, 0) < noise_pct) push_item(1'b0, 24'($urandom));
      push_item(1'b1, 24'($urandom));
      items_sent++;
    end
    frames_run++;
  endtask

  initial begin
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; command = 0; red_in = 0; green_in = 0; blue_in = 0;
    out_stall = 0;
    send_idle = 21; recv_idle = 56; hold_cycles = 0; cycle_cnt = 0;
    items_sent = 0; frames_run = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    run_frame(3, 3, 1, 30);
    run_frame(0, 0, 0, 50);
    run_frame(2, 2, 1, 0);
    run_frame(1, 3, 1, 20);

    hold_cycles = 600;
    while (items_sent < 950) begin
      if (items_sent < 317) begin
        send_idle = 21; recv_idle = 56;
      end else if (items_sent < 634) begin
        send_idle = 56; recv_idle = 21;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      run_frame($urandom_range(14, 0), $urandom_range(8, 0), 0, 6);
    end

    settle();
    $display("covered %0d frames, %0d counted input items, %0d edge results checked",
             frames_run, items_sent, results_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== sobel_edge_rgb_stream.f =====
+incdir+rtl/core
rtl/core/ser_pkg.sv
rtl/core/ser_ram.sv
rtl/core/ser_datapath.sv
rtl/core/ser_ctrl.sv
rtl/core/sobel_edge_rgb_stream.sv
bench/sobel_edge_rgb_stream_chk.sv
bench/sobel_edge_rgb_stream_tb.sv
